/* sv/two_electrode_touch_slider_defines.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the two-electrode touch slider
// Checks are compiled for simulation and drop out when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef TWO_ELECTRODE_TOUCH_SLIDER_DEFINES_SVH
`define TWO_ELECTRODE_TOUCH_SLIDER_DEFINES_SVH

`ifndef SYNTHESIS
// Property checked on every rising clock edge outside of reset.
`define TETS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Property checked on every rising clock edge, reset included.
`define TETS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TETS_ASSERT(label, prop, msg)
`define TETS_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

/* sv/tets_pkg.sv */
// ---------------------------------------------------------------------------
// Touch slider package
// Widths, codes and the command and status bundles shared by the modules.
// ---------------------------------------------------------------------------
package tets_pkg;

  localparam int COUNT_W = 16;
  localparam int DELTA_W = 15;
  localparam int POS_W   = 7;
  localparam int PROD_W  = DELTA_W + POS_W;
  localparam int REG_IDX_W = 2;

  // Full scale of the slider position.
  localparam logic [POS_W-1:0] POS_SCALE = 7'd100;
  localparam logic [COUNT_W-1:0] THRESHOLD_RESET = 16'd100;

  // Quotient bits produced by the serial divider; the quotient never exceeds 100.
  localparam int DIV_STEPS = POS_W;

  // Operation codes carried in tuser.
  localparam logic OP_SCAN = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Configuration register indexes.
  localparam logic [REG_IDX_W-1:0] REG_BASELINE_0 = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_BASELINE_1 = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_THRESHOLD  = 2'd2;

  typedef struct packed {
    logic scan_update;  // store the delta of the active electrode
    logic read_start;   // clear the fresh flag and load the first division
    logic div_step;     // one restoring division step
    logic div_load_b;   // save the first quotient and load the second division
    logic res_load;     // place the position in the output register
  } cmd_t;

  typedef struct packed {
    logic compute;   // fresh scan pending and a touch present
    logic div_last;  // the current division step is the last one
    logic out_free;  // output register can take a result this cycle
  } status_t;

endpackage

/* sv/tets_ctrl.sv */
// ---------------------------------------------------------------------------
// Touch slider controller
// Sequences scan updates, the two position divisions and the result push.
// ---------------------------------------------------------------------------
module tets_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  input  logic             s_tuser,
  output logic             s_tready,
  input  tets_pkg::status_t status,
  output tets_pkg::cmd_t    cmd
);
  import tets_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DIV_A  = 5'b00010,
    S_LOAD_B = 5'b00100,
    S_DIV_B  = 5'b01000,
    S_PUSH   = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (s_tuser == OP_SCAN) begin
            cmd.scan_update = 1'b1;
          end else begin
            cmd.read_start = 1'b1;
            state_next = status.compute ? S_DIV_A : S_PUSH;
          end
        end
      end
      S_DIV_A: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = S_LOAD_B;
        end
      end
      S_LOAD_B: begin
        cmd.div_load_b = 1'b1;
        state_next = S_DIV_B;
      end
      S_DIV_B: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = S_PUSH;
        end
      end
      S_PUSH: begin
        if (status.out_free) begin
          cmd.res_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* sv/tets_dp.sv */
// ---------------------------------------------------------------------------
// Touch slider datapath
// Configuration, electrode deltas, shared serial divider and output register.
// ---------------------------------------------------------------------------
module tets_dp (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [tets_pkg::REG_IDX_W-1:0]        cfg_index,
  input  logic [tets_pkg::COUNT_W-1:0]          cfg_data,
  input  logic [tets_pkg::COUNT_W-1:0]          scan_count,
  input  tets_pkg::cmd_t                        cmd,
  output tets_pkg::status_t                     status,
  input  logic                                  m_tready,
  output logic                                  m_tvalid,
  output logic [tets_pkg::POS_W-1:0]            m_pos
);
  import tets_pkg::*;

  localparam logic [2:0] DIV_LAST_CNT = 3'(DIV_STEPS - 1);

  logic [COUNT_W-1:0] baseline_0;
  logic [COUNT_W-1:0] baseline_1;
  logic [COUNT_W-1:0] threshold;
  logic [DELTA_W-1:0] delta_0;
  logic [DELTA_W-1:0] delta_1;
  logic               active;
  logic               fresh;

  logic [COUNT_W-1:0] sum;
  logic [COUNT_W-1:0] rem;
  logic [POS_W-1:0]   low;
  logic [POS_W-1:0]   quot;
  logic [POS_W-1:0]   quot_a;
  logic [2:0]         cnt;
  logic               pos_zero;
  logic [POS_W-1:0]   out_pos;
  logic               out_valid;

  logic [COUNT_W-1:0] diff;
  logic [DELTA_W-1:0] new_delta;
  logic [DELTA_W-1:0] mul_in;
  logic [PROD_W-1:0]  prod;
  logic [COUNT_W:0]   trial;
  logic               q_bit;
  logic [POS_W:0]     pos_sum;
  logic               touch;

  always_ff @(posedge clk) begin
    if (rst) begin
      baseline_0 <= '0;
      baseline_1 <= '0;
      threshold  <= THRESHOLD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BASELINE_0: baseline_0 <= cfg_data;
        REG_BASELINE_1: baseline_1 <= cfg_data;
        REG_THRESHOLD:  threshold  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // A difference with the sign bit set is taken as a count below baseline.
  assign diff      = scan_count - (active ? baseline_1 : baseline_0);
  assign new_delta = diff[COUNT_W-1] ? '0 : diff[DELTA_W-1:0];

  assign touch = ({1'b0, delta_0} > threshold) || ({1'b0, delta_1} > threshold);

  always_ff @(posedge clk) begin
    if (rst) begin
      delta_0 <= '0;
      delta_1 <= '0;
      active  <= 1'b0;
      fresh   <= 1'b1;
    end else if (cmd.scan_update) begin
      if (active) begin
        delta_1 <= new_delta;
      end else begin
        delta_0 <= new_delta;
      end
      active <= ~active;
      fresh  <= 1'b1;
    end else if (cmd.read_start) begin
      fresh <= 1'b0;
    end
  end

  // Scaled numerator for either division.
  assign mul_in = cmd.div_load_b ? delta_1 : delta_0;
  assign prod   = PROD_W'(mul_in) * PROD_W'(POS_SCALE);

  // The numerator is below 128 times the divisor, so its upper bits start
  // as a remainder that is already smaller than the divisor.
  assign trial = {rem, low[POS_W-1]};
  assign q_bit = trial >= {1'b0, sum};

  always_ff @(posedge clk) begin
    if (cmd.read_start) begin
      sum      <= COUNT_W'(delta_0) + COUNT_W'(delta_1);
      pos_zero <= ~status.compute;
    end
    if (cmd.read_start || cmd.div_load_b) begin
      rem <= {1'b0, prod[PROD_W-1:POS_W]};
      low <= prod[POS_W-1:0];
      cnt <= DIV_LAST_CNT;
    end else if (cmd.div_step) begin
      rem  <= q_bit ? COUNT_W'(trial - {1'b0, sum}) : trial[COUNT_W-1:0];
      low  <= {low[POS_W-2:0], 1'b0};
      quot <= {quot[POS_W-2:0], q_bit};
      cnt  <= cnt - 3'd1;
    end
    if (cmd.div_load_b) begin
      quot_a <= quot;
    end
  end

  // 100 - a + b lies in 0..200.
  assign pos_sum = (POS_W+1)'(POS_SCALE) - {1'b0, quot_a} + {1'b0, quot};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_pos <= pos_zero ? '0 : pos_sum[POS_W:1];
    end
  end

  assign status.compute  = fresh && touch;
  assign status.div_last = (cnt == 3'd0);
  assign status.out_free = ~out_valid || m_tready;

  assign m_tvalid = out_valid;
  assign m_pos    = out_pos;

endmodule

/* sv/two_electrode_touch_slider.sv */
// ---------------------------------------------------------------------------
// Two-electrode capacitive touch slider
// Turns alternating electrode scan counts into a 0..100 finger position.
// ---------------------------------------------------------------------------
// Each input request on the slave stream is either a scan result (tuser = 0,
// tdata = 16-bit oscillator count for the electrode whose turn it is; the
// electrodes alternate starting with electrode 0) or a position read
// (tuser = 1). A scan produces nothing on the master stream. A read produces
// exactly one result request carrying the position. A read that finds no
// fresh scan or no touch goes straight to the result push. A read that needs
// the position goes through a shared serial divider, one quotient bit per
// cycle, twice for seven bits each, before its result is pushed. The input is
// blocked while a read is in progress, so the division sets the sustained
// read rate.
// The master side has an output register: further scans are taken while a
// result waits, and a stalled receiver only holds back the next read.
// Configuration writes on cfg_we/cfg_index/cfg_data take effect at once and
// are expected while the block is idle. Reset clears the deltas and the
// electrode turn, sets the fresh flag, loads baselines 0 and threshold 100.
// ---------------------------------------------------------------------------
`include "two_electrode_touch_slider_defines.svh"

module two_electrode_touch_slider (
  input  logic                                  clk,
  input  logic                                  rst,
  // Configuration write port.
  input  logic                                  cfg_we,
  input  logic [tets_pkg::REG_IDX_W-1:0]        cfg_index,
  input  logic [tets_pkg::COUNT_W-1:0]          cfg_data,
  // Slave stream.
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [15:0]                           s_tdata,   // [15:0] scan_count
  input  logic                                  s_tuser,   // [0] operation
  // Master stream.
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [7:0]                            m_tdata    // [6:0] slider_position
);
  import tets_pkg::*;

  cmd_t             cmd;
  status_t          status;
  logic [POS_W-1:0] pos;

  // The controller only sequences; every value lives in the datapath.
  tets_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tuser  (s_tuser),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  tets_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .scan_count (s_tdata[COUNT_W-1:0]),
    .cmd        (cmd),
    .status     (status),
    .m_tready   (m_tready),
    .m_tvalid   (m_tvalid),
    .m_pos      (pos)
  );

  assign m_tdata = {1'b0, pos};

  // A read occupies the block until its result is in the output register.
  `TETS_ASSERT(a_read_blocks_input, (s_tvalid && s_tready && (s_tuser == OP_READ)) |=> !s_tready, "input accepted during a read")
  // A new result is only loaded when the pending one is gone or leaving.
  `TETS_ASSERT(a_no_overwrite, cmd.res_load |-> status.out_free, "pending result overwritten")
  // The reported position never leaves its range.
  `TETS_ASSERT(a_pos_range, m_tvalid |-> (pos <= POS_SCALE), "position above full scale")
  // Scan updates and read starts only happen on an accepted request.
  `TETS_ASSERT_ALWAYS(a_cmd_on_accept, (cmd.scan_update || cmd.read_start) |-> (s_tvalid && s_tready), "command without request")

endmodule
